// ===== sv/ubh_pkg.sv =====
// ----------------------------------------------------------------------------
// ubh_pkg
// Shared types and constants of the uniform-width histogram.
// ----------------------------------------------------------------------------
package ubh_pkg;

  localparam int MAX_BINS = 256;
  localparam int BIN_W    = $clog2(MAX_BINS);
  localparam int CNT_W    = 32;
  localparam int DIFF_W   = 33;
  localparam int QUO_W    = 34;
  localparam int NB_W     = 9;

  localparam logic [1:0] REG_RANGE_START = 2'd0;
  localparam logic [1:0] REG_BIN_WIDTH   = 2'd1;
  localparam logic [1:0] REG_BINS_IN_USE = 2'd2;

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Request handed from the index stage to the bin store
  typedef struct packed {
    logic             is_read;
    logic             hit;
    logic [BIN_W-1:0] bin;
  } bin_req_t;

endpackage

// ===== sv/ubh_divider.sv =====
// ----------------------------------------------------------------------------
// ubh_divider
// Bit-serial floor division of the sample offset by the bin width; maps the
// quotient to a bin with the left-open rule and flags out-of-range samples.
// ----------------------------------------------------------------------------
module ubh_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [31:0]            sample,
  input  logic signed [31:0]            range_start,
  input  logic [30:0]                   bin_width,
  input  logic [ubh_pkg::NB_W-1:0]      nbins,
  output logic                          busy,
  output logic                          done,
  output ubh_pkg::bin_req_t             req
);
  import ubh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_FIN  = 3'b100
  } div_state_t;

  div_state_t        state, state_next;
  logic              neg;
  logic [31:0]       mag;
  logic [31:0]       quo;
  logic [31:0]       rem;
  logic [5:0]        cnt;
  logic [32:0]       trial;
  logic [32:0]       mag_ext;
  logic signed [DIFF_W-1:0] diff;
  logic signed [QUO_W-1:0]  q_fl;
  logic signed [QUO_W-1:0]  q_adj;
  logic              rem_zero;

  assign diff    = DIFF_W'(sample) - DIFF_W'(range_start);
  assign mag_ext = diff[DIFF_W-1] ? 33'(-diff) : 33'(diff);
  assign trial   = {rem, mag[31]} - {2'b0, bin_width};

  // Sequence the restoring division, one quotient bit a cycle
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start) state_next = S_DIV;
      S_DIV:   if (cnt == 6'd31) state_next = S_FIN;
      S_FIN:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Magnitude stays below 2^32, so bit 32 is never set; it is kept apart in top
  logic top;
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      neg <= diff[DIFF_W-1];
      top <= mag_ext[32];
      mag <= mag_ext[31:0];
      quo <= '0;
      rem <= {31'b0, mag_ext[32]};
      cnt <= '0;
    end else if (state == S_DIV) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], mag[31]};
        quo <= {quo[30:0], 1'b0};
      end
      mag <= {mag[30:0], 1'b0};
      cnt <= cnt + 6'd1;
    end
  end

  // Top bit preloaded into rem contributes quotient weight 2^32 only when
  // width is 1; rem < width keeps it exact otherwise (rem<2^31 always)
  logic [QUO_W-1:0] q_mag;
  always_comb begin
    q_mag    = {2'b0, quo};
    rem_zero = (rem == 32'd0);
    if (top && bin_width == 31'd1) q_mag = QUO_W'(34'h1_0000_0000);
    q_fl = neg ? (rem_zero ? -$signed(q_mag) : -$signed(q_mag) - 34'sd1)
               : $signed(q_mag);
    q_adj = q_fl;
    if (rem_zero || q_fl == $signed(QUO_W'(nbins))) q_adj = q_fl - 34'sd1;
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= (state == S_FIN);
    if (state == S_FIN) begin
      req.is_read <= 1'b0;
      req.hit     <= (bin_width != '0) && !q_adj[QUO_W-1] &&
                     (q_adj < $signed(QUO_W'(nbins)));
      req.bin     <= q_adj[BIN_W-1:0];
    end
  end

  assign busy = (state != S_IDLE) || done;

`ifndef NO_ASSERTIONS
  a_fin_from_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> $past(state == S_DIV)) else $error("fin without div");
  a_done_after_fin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_FIN)) else $error("stray done");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |=> (state == S_DIV || state == S_FIN))
    else $error("division aborted");
`endif
endmodule

// ===== sv/ubh_store.sv =====
// ----------------------------------------------------------------------------
// ubh_store
// Bin counter memory with read-modify-write and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module ubh_store (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  ubh_pkg::bin_req_t           req,
  output logic                        clearing,
  output logic                        done,
  output logic [ubh_pkg::BIN_W-1:0]   out_bin,
  output logic                        out_hit,
  output logic [ubh_pkg::CNT_W-1:0]   out_total
);
  import ubh_pkg::*;

  logic [CNT_W-1:0] mem [MAX_BINS];
  logic [CNT_W-1:0] rdata;
  logic [BIN_W:0]   clr_cnt;
  logic             ph_rd;
  bin_req_t         hold;
  logic [CNT_W-1:0] upd;

  assign clearing = !clr_cnt[BIN_W];

  // Sweep counter, then read phase, then write/answer phase
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      ph_rd   <= 1'b0;
      done    <= 1'b0;
    end else begin
      if (clearing) clr_cnt <= clr_cnt + 1'b1;
      ph_rd <= go;
      done  <= ph_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (go) hold <= req;
    rdata <= mem[req.bin];
  end

  assign upd = (rdata == '1) ? rdata : rdata + 1'b1;

  // Write back the sweep or the incremented count
  always_ff @(posedge clk) begin
    if (clearing) mem[clr_cnt[BIN_W-1:0]] <= '0;
    else if (ph_rd && hold.hit && !hold.is_read) mem[hold.bin] <= upd;
  end

  always_ff @(posedge clk) begin
    if (ph_rd) begin
      out_bin   <= hold.hit ? hold.bin : (hold.is_read ? hold.bin : '0);
      out_hit   <= hold.hit;
      out_total <= !hold.hit ? '0 : (hold.is_read ? rdata : upd);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_go_clear: assert property (@(posedge clk) disable iff (rst)
    go |-> !clearing) else $error("request during clear");
  a_done_seq: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(ph_rd)) else $error("stray done");
  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    !clearing |=> !clearing) else $error("clear restarted");
`endif
endmodule

// ===== sv/uniform_bin_histogram.sv =====
// ----------------------------------------------------------------------------
// uniform_bin_histogram
// Equal-width histogram over Q16.16 samples with bin readback.
// ----------------------------------------------------------------------------
// One request at a time. An add passes through the 32-step bit-serial divider
// and then the bin store; a read skips the divider and uses only the memory
// read and output register. After reset the block clears the counter memory
// before it accepts requests.
module uniform_bin_histogram (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tuser,   // [0] req_type
  input  logic [39:0] s_tdata,   // [31:0] sample, [39:32] read_bin
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic        m_tuser,   // [0] in_range
  output logic [39:0] m_tdata,   // [7:0] bin_index, [39:8] bin_total
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import ubh_pkg::*;

  logic signed [31:0] range_start;
  logic [30:0]        bin_width;
  logic [8:0]         bins_in_use;
  logic [NB_W-1:0]    nbins;
  logic               busy, active;
  logic               take, d_busy, d_done, s_clear, s_done;
  bin_req_t           d_req, rd_req, st_req;
  logic               st_go;
  logic [BIN_W-1:0]   o_bin;
  logic               o_hit;
  logic [CNT_W-1:0]   o_total;
  logic               rd_pend;

  assign cfg_ready = 1'b1;
  assign nbins     = (bins_in_use > 9'(MAX_BINS)) ? NB_W'(MAX_BINS) : bins_in_use;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      range_start <= '0;
      bin_width   <= 31'd65536;
      bins_in_use <= 9'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RANGE_START: range_start <= cfg_data;
        REG_BIN_WIDTH:   bin_width   <= cfg_data[30:0];
        REG_BINS_IN_USE: bins_in_use <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  assign s_tready = !busy && !s_clear;
  assign take     = s_tvalid && s_tready;

  // One request in flight until its result transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      if (take) active <= 1'b1;
      else if (m_tvalid && m_tready) active <= 1'b0;
      rd_pend <= take && (s_tuser[0] == REQ_READ);
    end
    if (take) begin
      rd_req.is_read <= 1'b1;
      rd_req.bin     <= s_tdata[39:32];
      rd_req.hit     <= {1'b0, s_tdata[39:32]} < nbins;
    end
  end
  assign busy = active || d_busy;

  ubh_divider u_div (
    .clk, .rst,
    .start(take && s_tuser[0] == REQ_ADD),
    .sample(s_tdata[31:0]),
    .range_start, .bin_width, .nbins,
    .busy(d_busy), .done(d_done), .req(d_req)
  );

  assign st_go  = d_done || rd_pend;
  assign st_req = rd_pend ? rd_req : d_req;

  ubh_store u_store (
    .clk, .rst, .go(st_go), .req(st_req),
    .clearing(s_clear), .done(s_done),
    .out_bin(o_bin), .out_hit(o_hit), .out_total(o_total)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (s_done) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
    if (s_done) begin
      m_tdata <= {o_total, o_bin};
      m_tuser <= o_hit;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    take |-> !active) else $error("overlap");
  a_valid_active: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> active) else $error("result without request");
  a_div_idle_read: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> !d_done) else $error("store conflict");
`endif
endmodule

// ===== verif/tb_uniform_bin_histogram.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uniform_bin_histogram
// Self-checking bench for the equal-width histogram: a directed table, then
// random add/read traffic over several register settings, each transfer
// checked in order against a behavioral copy of the bin store.
// ----------------------------------------------------------------------------
module tb_uniform_bin_histogram;
  import ubh_pkg::*;

  typedef struct packed {
    logic [7:0]  bin_index;
    logic        in_range;
    logic [31:0] bin_total;
  } bin_result_t;

  typedef struct {
    logic        kind;
    logic [31:0] sample;
    logic [7:0]  read_bin;
    logic        known;
    bin_result_t result;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tuser = '0;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic        m_tuser;
  logic [39:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Predictor state
  logic signed [31:0] pred_start;
  logic [30:0]        pred_width;
  logic [8:0]         pred_bins;
  logic [31:0]        pred_counts [MAX_BINS];

  bin_result_t expected_results [$];
  int  mismatches = 0;
  bit  idle_free = 1'b0;
  int  hold_off = 0;

  uniform_bin_histogram uut (.*);

  always #6 clk = ~clk;

  // Compute the result of one request and update the predicted store
  function automatic bin_result_t histogram_step(logic kind, logic [31:0] smp,
                                                 logic [7:0] rb);
    bin_result_t res;
    longint nb, d, w, q, r;
    res = '0;
    nb = (pred_bins > MAX_BINS) ? MAX_BINS : pred_bins;
    if (kind == REQ_READ) begin
      res.bin_index = rb;
      if (rb < nb) begin
        res.in_range = 1'b1;
        res.bin_total = pred_counts[rb];
      end
      return res;
    end
    if (pred_width == 0) return res;
    d = longint'($signed(smp)) - longint'(pred_start);
    w = pred_width;
    q = d / w;
    r = d % w;
    if (r < 0) begin
      r += w;
      q -= 1;
    end
    if (r == 0 || q == nb) q -= 1;
    if (q >= 0 && q < nb) begin
      if (pred_counts[q] != 32'hFFFF_FFFF) pred_counts[q] += 1;
      res.bin_index = q[7:0];
      res.in_range = 1'b1;
      res.bin_total = pred_counts[q];
    end
    return res;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_RANGE_START: pred_start = val;
      REG_BIN_WIDTH:   pred_width = val[30:0];
      default:         pred_bins  = val[8:0];
    endcase
  endtask

  // Offer one request; hold valid until the transfer
  task automatic send_request(logic kind, logic [31:0] smp, logic [7:0] rb,
                              logic known, bin_result_t typed);
    bin_result_t res;
    while (!idle_free && $urandom_range(99) < 38) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= {7'd0, kind};
    s_tdata  <= {rb, smp};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    res = histogram_step(kind, smp, rb);
    if (known && res !== typed) begin
      mismatches++;
      if (mismatches <= 10)
        $display("typed row disagrees with predictor: typed %h pred %h", typed, res);
    end
    expected_results.push_back(res);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(5))
      0: return $urandom();
      1: return pred_start + $urandom_range(3) * pred_width;
      2: return pred_start + $urandom_range(3) * pred_width + 1;
      3: return pred_start + ($urandom_range(pred_bins + 1) * pred_width)
             + ($urandom_range(1) ? 0 : 32'hFFFF_FFFF);
      default: return pred_start + $urandom_range(32'h7FFF) * (pred_width + 1) / 32;
    endcase
  endfunction

  // Receiver side: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= idle_free || ($urandom_range(99) >= 38);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    bin_result_t got, exp_r;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[7:0], m_tuser, m_tdata[39:8]};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %h actual %h", exp_r, got);
        end
      end
    end
  end

  initial begin
    #60_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    stim_row_t rows [$];
    int phase;
    pred_start = 0;
    pred_width = 31'd65536;
    pred_bins  = 9'd256;
    foreach (pred_counts[i]) pred_counts[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed table: reset contents, extremes, edges, drops
    rows = '{
      '{REQ_READ, 32'd0, 8'd0,   1'b1, '{8'd0, 1'b1, 32'd0}},
      '{REQ_READ, 32'd0, 8'd255, 1'b1, '{8'd255, 1'b1, 32'd0}},
      '{REQ_ADD,  32'h0001_0000, 8'd0, 1'b1, '{8'd0, 1'b1, 32'd1}},
      '{REQ_ADD,  32'h0000_0001, 8'd0, 1'b1, '{8'd0, 1'b1, 32'd2}},
      '{REQ_ADD,  32'h0000_0000, 8'd0, 1'b1, '{8'd0, 1'b0, 32'd0}},
      '{REQ_ADD,  32'h8000_0000, 8'd0, 1'b1, '{8'd0, 1'b0, 32'd0}},
      '{REQ_ADD,  32'h0100_0000, 8'd0, 1'b1, '{8'd255, 1'b1, 32'd1}},
      '{REQ_ADD,  32'h0100_0001, 8'd0, 1'b1, '{8'd255, 1'b1, 32'd2}},
      '{REQ_ADD,  32'h7FFF_FFFF, 8'd0, 1'b1, '{8'd0, 1'b0, 32'd0}},
      '{REQ_ADD,  32'h0001_8000, 8'hFF, 1'b0, '0},
      '{REQ_READ, 32'hFFFF_FFFF, 8'd1, 1'b0, '0},
      '{REQ_READ, 32'd0, 8'd0,   1'b1, '{8'd0, 1'b1, 32'd2}}
    };
    foreach (rows[i])
      send_request(rows[i].kind, rows[i].sample, rows[i].read_bin,
                   rows[i].known, rows[i].result);
    drain();

    // Zero width drops everything; zero and oversized bin counts
    write_reg(REG_BIN_WIDTH, 32'd0);
    send_request(REQ_ADD, 32'h0000_8000, 8'd0, 1'b1, '{8'd0, 1'b0, 32'd0});
    drain();
    write_reg(REG_BINS_IN_USE, 32'd0);
    write_reg(REG_BIN_WIDTH, 32'd1);
    drain();
    send_request(REQ_ADD, 32'd1, 8'd0, 1'b1, '{8'd0, 1'b0, 32'd0});
    send_request(REQ_READ, 32'd0, 8'd0, 1'b1, '{8'd0, 1'b0, 32'd0});
    drain();
    write_reg(REG_BINS_IN_USE, 32'h1FF);
    send_request(REQ_READ, 32'd0, 8'd255, 1'b1, '{8'd255, 1'b1, 32'd2});
    drain();

    // Random phases over several settings
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin write_reg(REG_RANGE_START, 32'h8000_0000);
                 write_reg(REG_BIN_WIDTH, 32'h7FFF_FFFF);
                 write_reg(REG_BINS_IN_USE, 32'd2); end
        1: begin write_reg(REG_RANGE_START, 32'h7FFF_FFFF);
                 write_reg(REG_BIN_WIDTH, 32'd1);
                 write_reg(REG_BINS_IN_USE, 32'd1); end
        2: begin write_reg(REG_RANGE_START, 32'hFFFF_0000);
                 write_reg(REG_BIN_WIDTH, 32'd3);
                 write_reg(REG_BINS_IN_USE, 32'd256); end
        default: begin write_reg(REG_RANGE_START, $urandom());
                 write_reg(REG_BIN_WIDTH, $urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(30));
                 write_reg(REG_BINS_IN_USE, $urandom_range(1, 300)); end
      endcase
      idle_free = (phase == 5);
      if (phase == 3) hold_off = 400;
      repeat (200) begin
        if ($urandom_range(3) == 0)
          send_request(REQ_READ, $urandom(), $urandom(), 1'b0, '0);
        else
          send_request(REQ_ADD, rand_sample(), $urandom(), 1'b0, '0);
      end
      drain();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== uniform_bin_histogram.f =====
sv/ubh_pkg.sv
sv/ubh_divider.sv
sv/ubh_store.sv
sv/uniform_bin_histogram.sv
verif/tb_uniform_bin_histogram.sv
